// ----- design/iee_pkg.sv -----
// shared types and constants for the infix expression evaluator
`default_nettype none
package iee_pkg;
	typedef enum logic [2:0] {
		OP_OPEN = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADCHAR = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_STACK   = 2'd3
	} status_t;

	// symbol classes
	typedef enum logic [2:0] {
		SC_DIGIT = 3'd0,
		SC_ADDSUB = 3'd1,
		SC_MULDIV = 3'd2,
		SC_OPEN  = 3'd3,
		SC_CLOSE = 3'd4,
		SC_BAD   = 3'd5
	} sym_class_t;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_STAR  = 8'd42;
	localparam logic [7:0] CHAR_SLASH = 8'd47;
	localparam logic [7:0] CHAR_OPEN  = 8'd40;
	localparam logic [7:0] CHAR_CLOSE = 8'd41;

	// datapath commands
	typedef struct packed {
		logic load;       // capture symbol
		logic push_digit; // push digit operand
		logic push_op;    // push captured operator
		logic pop_op;     // drop top operator
		logic red_start;  // pop two operands, start arithmetic
		logic red_finish; // push arithmetic result
		logic clear;      // empty both stacks
	} dp_cmd_t;

	// datapath status
	typedef struct packed {
		sym_class_t cls;
		logic       opd_full;
		logic       opd_lt2;
		logic       opd_empty;
		logic       opr_full;
		logic       opr_empty;
		op_t        opr_top;
		logic       arith_done;
		logic       div_zero;
	} dp_sts_t;
endpackage
`default_nettype wire

// ----- design/iee_divider.sv -----
// iterative signed divider truncating toward zero, one quotient bit per cycle
`default_nettype none
module iee_divider import iee_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q, busy_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	// restoring division over magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
				rem_q  <= '0;
				quo_q  <= dividend[W-1] ? W'(-dividend) : dividend;
				dvs_q  <= divisor[W-1] ? W'(-divisor) : divisor;
				neg_q  <= dividend[W-1] ^ divisor[W-1];
			end else if (busy_q) begin
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[W-2:0], quo_q[W-1]};
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? W'(-quo_q) : quo_q;
endmodule
`default_nettype wire

// ----- design/iee_datapath.sv -----
// operand and operator stacks with the arithmetic unit
`default_nettype none
module iee_datapath import iee_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             symbol,
	input  dp_cmd_t                     cmd,
	output dp_sts_t                     sts,
	output logic [VALUE_WIDTH-1:0]      top_value
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int W  = VALUE_WIDTH;

	logic [W-1:0]  opd_mem [STACK_DEPTH];
	logic [2:0]    opr_mem [STACK_DEPTH];
	logic [CW-1:0] opd_cnt_q, opr_cnt_q;
	logic [W-1:0]  top_q, next_q;
	op_t           opr_top_q;
	logic [7:0]    sym_q;
	sym_class_t    cls;
	op_t           sym_op;
	logic [W-1:0]  a_q, b_q, res_q;
	op_t           aop_q;
	logic          arith_q, arith_done_q, div_start_q;
	logic          div_done;
	logic [W-1:0]  div_quo;

	// classify captured symbol
	always_comb begin
		sym_op = OP_OPEN;
		if (sym_q >= CHAR_ZERO && sym_q <= CHAR_NINE) cls = SC_DIGIT;
		else if (sym_q == CHAR_PLUS) begin cls = SC_ADDSUB; sym_op = OP_ADD; end
		else if (sym_q == CHAR_MINUS) begin cls = SC_ADDSUB; sym_op = OP_SUB; end
		else if (sym_q == CHAR_STAR) begin cls = SC_MULDIV; sym_op = OP_MUL; end
		else if (sym_q == CHAR_SLASH) begin cls = SC_MULDIV; sym_op = OP_DIV; end
		else if (sym_q == CHAR_OPEN) cls = SC_OPEN;
		else if (sym_q == CHAR_CLOSE) cls = SC_CLOSE;
		else cls = SC_BAD;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) sym_q <= symbol;
	end

	// counts and cached top entries; memory holds everything below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opd_cnt_q <= '0;
			opr_cnt_q <= '0;
		end else if (cmd.clear) begin
			opd_cnt_q <= '0;
			opr_cnt_q <= '0;
		end else begin
			if (cmd.push_digit || cmd.red_finish) opd_cnt_q <= opd_cnt_q + 1'b1;
			else if (cmd.red_start) opd_cnt_q <= opd_cnt_q - CW'(2);
			if (cmd.push_op) opr_cnt_q <= opr_cnt_q + 1'b1;
			else if (cmd.pop_op || cmd.red_start) opr_cnt_q <= opr_cnt_q - 1'b1;
		end
	end

	// operand stack: entry cnt-1 in top_q, cnt-2 in next_q, read data registered
	always_ff @(posedge clk) begin
		if (cmd.push_digit || cmd.red_finish) begin
			if (opd_cnt_q != '0) opd_mem[AW'(opd_cnt_q - 1'b1)] <= top_q;
			next_q <= top_q;
			top_q  <= cmd.red_finish ? res_q : W'({4'd0, sym_q[3:0]} - 8'd0);
		end else if (cmd.red_start) begin
			a_q <= next_q;
			b_q <= top_q;
			aop_q <= opr_top_q;
			if (opd_cnt_q > CW'(2)) top_q <= opd_mem[AW'(opd_cnt_q - CW'(3))];
			if (opd_cnt_q > CW'(3)) next_q <= opd_mem[AW'(opd_cnt_q - CW'(4))];
		end
	end

	// operator stack with cached top
	always_ff @(posedge clk) begin
		if (cmd.push_op) begin
			if (opr_cnt_q != '0) opr_mem[AW'(opr_cnt_q - 1'b1)] <= opr_top_q;
			opr_top_q <= (cls == SC_OPEN) ? OP_OPEN : sym_op;
		end else if ((cmd.pop_op || cmd.red_start) && opr_cnt_q > CW'(1)) begin
			opr_top_q <= op_t'(opr_mem[AW'(opr_cnt_q - CW'(2))]);
		end
	end

	// arithmetic: add, sub, mul computed directly into the result register; divider for div
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arith_q      <= 1'b0;
			arith_done_q <= 1'b0;
			div_start_q  <= 1'b0;
		end else begin
			arith_q      <= cmd.red_start;
			div_start_q  <= 1'b0;
			arith_done_q <= 1'b0;
			if (arith_q) begin
				unique case (aop_q)
					OP_ADD: begin res_q <= a_q + b_q; arith_done_q <= 1'b1; end
					OP_SUB: begin res_q <= a_q - b_q; arith_done_q <= 1'b1; end
					OP_MUL: begin res_q <= W'(a_q * b_q); arith_done_q <= 1'b1; end
					default: begin
						if (b_q == '0) arith_done_q <= 1'b1;
						else div_start_q <= 1'b1;
					end
				endcase
			end
			if (div_done) begin
				res_q <= div_quo;
				arith_done_q <= 1'b1;
			end
		end
	end

	iee_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.dividend(a_q), .divisor(b_q), .done(div_done), .quotient(div_quo)
	);

	always_comb begin
		sts.cls        = cls;
		sts.opd_full   = (opd_cnt_q == CW'(STACK_DEPTH));
		sts.opd_lt2    = (opd_cnt_q < CW'(2));
		sts.opd_empty  = (opd_cnt_q == '0);
		sts.opr_full   = (opr_cnt_q == CW'(STACK_DEPTH));
		sts.opr_empty  = (opr_cnt_q == '0);
		sts.opr_top    = opr_top_q;
		sts.arith_done = arith_done_q;
		sts.div_zero   = (aop_q == OP_DIV) && (b_q == '0);
	end

	assign top_value = top_q;
endmodule
`default_nettype wire

// ----- design/iee_ctrl.sv -----
// controller state machine for symbol handling and reductions
`default_nettype none
module iee_ctrl import iee_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic last,
	input  dp_sts_t   sts,
	output dp_cmd_t   cmd,
	output logic      busy,
	output logic      emit,
	output status_t   err
);
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_REDUCE = 6'b000100,
		S_WAIT   = 6'b001000,
		S_FINAL  = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t  state_q, state_d;
	status_t err_q, err_d;
	logic    last_q, fin_q, fin_d;

	// reduction wanted for current symbol (fin_q: end-of-expression drain)
	logic want_red;
	always_comb begin
		want_red = 1'b0;
		if (!sts.opr_empty && sts.opr_top != OP_OPEN) begin
			if (fin_q || sts.cls == SC_ADDSUB || sts.cls == SC_CLOSE) want_red = 1'b1;
			else if (sts.cls == SC_MULDIV &&
				(sts.opr_top == OP_MUL || sts.opr_top == OP_DIV)) want_red = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		fin_d   = fin_q;
		cmd     = '0;
		emit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (err_q != ST_OK) state_d = last_q ? S_FINAL : S_IDLE;
				else if (want_red) begin
					if (sts.opd_lt2) begin
						err_d = ST_STACK;
						cmd.pop_op = 1'b1;
						state_d = last_q ? S_FINAL : S_IDLE;
					end else begin
						cmd.red_start = 1'b1;
						state_d = S_WAIT;
					end
				end else begin
					state_d = last_q ? S_FINAL : S_IDLE;
					unique case (sts.cls)
						SC_DIGIT: if (sts.opd_full) err_d = ST_STACK;
							else cmd.push_digit = 1'b1;
						SC_ADDSUB, SC_MULDIV, SC_OPEN: if (sts.opr_full) err_d = ST_STACK;
							else cmd.push_op = 1'b1;
						SC_CLOSE: if (sts.opr_empty) err_d = ST_STACK;
							else cmd.pop_op = 1'b1;
						default: err_d = ST_BADCHAR;
					endcase
				end
			end
			S_WAIT: begin
				if (sts.arith_done) begin
					if (sts.div_zero) err_d = ST_DIVZERO;
					else cmd.red_finish = 1'b1;
					state_d = fin_q ? S_FINAL : S_DECODE;
				end
			end
			S_FINAL: begin
				fin_d = 1'b1;
				if (err_q != ST_OK) state_d = S_EMIT;
				else if (!sts.opr_empty && sts.opr_top == OP_OPEN) cmd.pop_op = 1'b1;
				else if (!sts.opr_empty) begin
					if (sts.opd_lt2) begin
						err_d = ST_STACK;
						cmd.pop_op = 1'b1;
					end else begin
						cmd.red_start = 1'b1;
						state_d = S_WAIT;
					end
				end else begin
					if (sts.opd_empty) err_d = ST_STACK;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				emit      = 1'b1;
				cmd.clear = 1'b1;
				err_d     = ST_OK;
				fin_d     = 1'b0;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ST_OK;
			fin_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			fin_q   <= fin_d;
			if (cmd.load) last_q <= last;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign err  = err_q;
endmodule
`default_nettype wire

// ----- design/infix_expression_evaluator.sv -----
// top level of the infix expression evaluator
// One transaction is one ASCII character with a last mark, taken when start is
// high and busy is low. Each reduction of a pending operator computes add,
// subtract or multiply directly and uses the one-bit-per-cycle divider for
// divide. After the last character the remaining operators are reduced and
// one result appears on value and status with done high for one cycle; it
// cannot be stalled. value is 0 whenever status is nonzero.
`default_nettype none
module infix_expression_evaluator import iee_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  symbol,
	input  wire logic        last,
	output logic             done,
	output logic [31:0]      value,
	output logic [1:0]       status
);
	dp_cmd_t                cmd;
	dp_sts_t                sts;
	logic                   emit;
	status_t                err;
	logic [VALUE_WIDTH-1:0] top;
	logic [63:0]            top_ext;

	iee_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last(last),
		.sts(sts), .cmd(cmd), .busy(busy), .emit(emit), .err(err)
	);

	iee_datapath #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .symbol(symbol), .cmd(cmd),
		.sts(sts), .top_value(top)
	);

	assign top_ext = 64'(signed'(top));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done   <= 1'b0;
			value  <= '0;
			status <= '0;
		end else begin
			done <= emit;
			if (emit) begin
				status <= err;
				value  <= (err == ST_OK) ? top_ext[31:0] : 32'd0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/iee_checker.sv -----
// port-level checks for the infix expression evaluator
`default_nettype none
module iee_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] value,
	input wire logic [1:0]  status
);
	// an error result carries zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != 2'd0 |-> value == 32'd0) else $error("error result nonzero");
	// results never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done twice");
	// accepted character makes block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after accept");
	// idle after a result
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy with result");
endmodule

bind infix_expression_evaluator iee_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .value(value), .status(status)
);
`default_nettype wire

// ----- sim/iee_checker.sv -----
// checker for the infix expression evaluator: predicts results and compares them
module iee_checker import iee_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [7:0]  symbol,
	input  wire logic        last,
	input  wire logic        done,
	input  wire logic [31:0] value,
	input  wire logic [1:0]  status,
	output int               fail_count,
	output int               pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
	} calc_result_t;

	logic [31:0]  num_stack [DEPTH];
	int           num_count;
	op_t          op_stack [DEPTH];
	int           op_count;
	status_t      err;
	calc_result_t results_q [$];

	function automatic status_t push_num(input logic [31:0] v);
		if (num_count >= DEPTH) return ST_STACK;
		num_stack[num_count] = v;
		num_count++;
		return ST_OK;
	endfunction

	function automatic status_t push_op(input op_t op);
		if (op_count >= DEPTH) return ST_STACK;
		op_stack[op_count] = op;
		op_count++;
		return ST_OK;
	endfunction

	// pop one operator and apply it to the top two operands
	function automatic status_t apply_top();
		op_t         op;
		logic [31:0] lhs, rhs, mag_l, mag_r, quo;
		logic [31:0] res;
		op_count--;
		op = op_stack[op_count];
		if (num_count < 2) return ST_STACK;
		rhs = num_stack[num_count - 1];
		lhs = num_stack[num_count - 2];
		num_count -= 2;
		case (op)
			OP_ADD: res = lhs + rhs;
			OP_SUB: res = lhs - rhs;
			OP_MUL: res = lhs * rhs;
			default: begin
				if (rhs == 0) return ST_DIVZERO;
				mag_l = lhs[31] ? -lhs : lhs;
				mag_r = rhs[31] ? -rhs : rhs;
				quo = mag_l / mag_r;
				res = (lhs[31] != rhs[31]) ? -quo : quo;
			end
		endcase
		return push_num(res);
	endfunction

	function automatic status_t take_symbol(input logic [7:0] sym);
		status_t e;
		e = ST_OK;
		if (sym >= CHAR_ZERO && sym <= CHAR_NINE) return push_num(32'(sym - CHAR_ZERO));
		if (sym == CHAR_PLUS || sym == CHAR_MINUS) begin
			while (e == ST_OK && op_count > 0 && op_stack[op_count - 1] != OP_OPEN)
				e = apply_top();
			if (e != ST_OK) return e;
			return push_op(sym == CHAR_PLUS ? OP_ADD : OP_SUB);
		end
		if (sym == CHAR_STAR || sym == CHAR_SLASH) begin
			while (e == ST_OK && op_count > 0 && op_stack[op_count - 1] >= OP_MUL)
				e = apply_top();
			if (e != ST_OK) return e;
			return push_op(sym == CHAR_STAR ? OP_MUL : OP_DIV);
		end
		if (sym == CHAR_OPEN) return push_op(OP_OPEN);
		if (sym == CHAR_CLOSE) begin
			forever begin
				if (op_count == 0) return ST_STACK;
				if (op_stack[op_count - 1] == OP_OPEN) begin
					op_count--;
					return ST_OK;
				end
				e = apply_top();
				if (e != ST_OK) return e;
			end
		end
		return ST_BADCHAR;
	endfunction

	// predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		calc_result_t r;
		if (!arst_n) begin
			num_count = 0;
			op_count = 0;
			err = ST_OK;
		end else if (start && !busy) begin
			if (err == ST_OK) err = take_symbol(symbol);
			if (last) begin
				while (err == ST_OK && op_count > 0) begin
					if (op_stack[op_count - 1] == OP_OPEN) op_count--;
					else err = apply_top();
				end
				if (err == ST_OK && num_count == 0) err = ST_STACK;
				r.status = err;
				r.value = (err == ST_OK) ? num_stack[num_count - 1] : 32'd0;
				results_q.push_back(r);
				num_count = 0;
				op_count = 0;
				err = ST_OK;
			end
		end
	end

	// compare each result against the oldest prediction
	initial fail_count = 0;
	always @(posedge clk) begin
		calc_result_t exp_r;
		if (arst_n && done) begin
			if (results_q.size() == 0) begin
				$error("unexpected result value=%0d status=%0d", $signed(value), status);
				fail_count++;
			end else begin
				exp_r = results_q.pop_front();
				if (value !== exp_r.value) begin
					$error("value: expected %0d, actual %0d", $signed(exp_r.value),
						$signed(value));
					fail_count++;
				end
				if (status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, status);
					fail_count++;
				end
			end
		end
	end

	assign pending_count = results_q.size();
endmodule

// ----- sim/tb.sv -----
// testbench top: stimulus for the infix expression evaluator and the verdict
module tb;
	import iee_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic        clk, arst_n, start, last, done;
	wire logic   busy;
	logic [7:0]  symbol;
	logic [31:0] value;
	logic [1:0]  status;
	int          fail_count, pending_count;
	int          idle_cycles;
	logic [7:0]  chars_q [$];

	infix_expression_evaluator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.symbol(symbol), .last(last), .done(done), .value(value), .status(status)
	);

	iee_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.symbol(symbol), .last(last), .done(done), .value(value), .status(status),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog on cycles with no transaction and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	// send one character, holding start until it is taken
	// the block is busy after an accept, so the task waits before raising start again
	task automatic send_char(input logic [7:0] c, input logic fin, input bit gap_ok);
		int gap;
		gap = gap_ok ? $urandom_range(0, 11) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap + 1) @(posedge clk);
		start <= 1'b1;
		symbol <= c;
		last <= fin;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		symbol <= 8'($urandom);
		last <= 1'($urandom);
	endtask

	task automatic send_expr(input bit gap_ok);
		while (chars_q.size() > 1) send_char(chars_q.pop_front(), 1'b0, gap_ok);
		send_char(chars_q.pop_front(), 1'b1, gap_ok);
	endtask

	function automatic logic [7:0] rand_digit();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0: return CHAR_PLUS;
			1: return CHAR_MINUS;
			2: return CHAR_STAR;
			default: return CHAR_SLASH;
		endcase
	endfunction

	// well-formed expression with random nesting
	task automatic build_expr(input int depth);
		int terms;
		terms = $urandom_range(1, 4);
		for (int k = 0; k < terms; k++) begin
			if (k > 0) chars_q.push_back(rand_op());
			if (depth > 0 && $urandom_range(0, 3) == 0) begin
				chars_q.push_back(CHAR_OPEN);
				build_expr(depth - 1);
				chars_q.push_back(CHAR_CLOSE);
			end else chars_q.push_back(rand_digit());
		end
	endtask

	task automatic directed(input string s);
		foreach (s[k]) chars_q.push_back(s[k]);
		send_expr(1'b1);
	endtask

	initial begin
		int sent;
		start = 0;
		symbol = 0;
		last = 0;
		arst_n = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: operators, precedence, errors, extremes
		directed("9-3-2");
		directed("8/2/2*3");
		directed("(7-9)/2");
		directed("9/0");
		directed("1+a");
		chars_q.push_back(8'd0); send_expr(1'b1);
		chars_q.push_back(8'd255); send_expr(1'b1);
		directed(")");
		directed("+");
		directed("((5");
		directed("123");
		directed("99999999999999999");
		directed("((((((((((((((((((1");
		directed("9*9*9*9*9*9*9*9*9*9*9");
		directed("0-9*9*9*9*9*9*9*9*9*9*9");
		// wait for everything before the random part
		while (pending_count != 0) @(posedge clk);

		// random: mostly well-formed, some noise
		sent = 0;
		while (sent < 1900) begin
			if ($urandom_range(0, 9) < 8) build_expr(3);
			else begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 3))
						0: chars_q.push_back(8'($urandom));
						1: chars_q.push_back(rand_op());
						2: chars_q.push_back($urandom_range(0, 1) ? CHAR_OPEN : CHAR_CLOSE);
						default: chars_q.push_back(rand_digit());
					endcase
				end
			end
			sent += chars_q.size();
			send_expr($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 99) == 0)
				while (pending_count != 0) @(posedge clk);
		end

		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule

// ----- filelist.f -----
design/iee_pkg.sv
design/iee_divider.sv
design/iee_datapath.sv
design/iee_ctrl.sv
design/infix_expression_evaluator.sv
design/iee_checker.sv
sim/iee_checker.sv
sim/tb.sv
